// ===== src/dshot4fe_pkg.sv =====
// Shared types, constants and packet builder for the four-lane DShot frame encoder.
package dshot4fe_pkg;

  localparam int FRAME_SLOTS = 18;
  localparam int MOTOR_LANES = 4;
  localparam int LANE_FIELDS = 4;
  localparam int DATA_SLOTS  = 16;
  localparam int SLOT_W      = $clog2(FRAME_SLOTS);
  localparam int VALUE_W     = 11;
  localparam int DUTY_W      = 8;
  localparam int PACKET_W    = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_ONE_BIT_DUTY  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_BIT_DUTY = CFG_INDEX_W'(1);

  localparam logic [DUTY_W-1:0] ONE_BIT_DUTY_RESET  = DUTY_W'(15);
  localparam logic [DUTY_W-1:0] ZERO_BIT_DUTY_RESET = DUTY_W'(7);

  typedef struct packed {
    logic [VALUE_W-1:0] motor0_value;
    logic [VALUE_W-1:0] motor1_value;
    logic [VALUE_W-1:0] motor2_value;
    logic [VALUE_W-1:0] motor3_value;
    logic               telemetry_request;
  } cmd_t;

  typedef struct packed {
    logic [4:0]        slot_number;
    logic [DUTY_W-1:0] motor0_duty;
    logic [DUTY_W-1:0] motor1_duty;
    logic [DUTY_W-1:0] motor2_duty;
    logic [DUTY_W-1:0] motor3_duty;
    logic              frame_end;
  } slot_t;

  typedef struct packed {
    logic load;
    logic shift;
  } lane_ctrl_t;

  // 12-bit word (value, telemetry) followed by the XOR of its three nibbles
  function automatic logic [PACKET_W-1:0] make_packet(input logic [VALUE_W-1:0] value,
                                                     input logic telemetry);
    logic [11:0] word;
    logic [3:0]  csum;
    word = {value, telemetry};
    csum = word[3:0] ^ word[7:4] ^ word[11:8];
    return {word, csum};
  endfunction

endpackage

// ===== src/dshot4fe_lane.sv =====
// One motor lane: builds the packet and shifts it out MSB first, one bit per slot.
module dshot4fe_lane
  import dshot4fe_pkg::*;
(
  input  logic                clk,
  input  lane_ctrl_t          ctrl,
  input  logic [VALUE_W-1:0]  value,
  input  logic                telemetry,
  output logic                bit_out
);

  logic [PACKET_W-1:0] packet;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      packet <= make_packet(value, telemetry);
    end else if (ctrl.shift) begin
      packet <= {packet[PACKET_W-2:0], 1'b0};
    end
  end

  assign bit_out = packet[PACKET_W-1];

endmodule

// ===== src/dshot_four_lane_frame_encoder_core.sv =====
// Four-lane DShot frame encoder: one command in, FRAME_SLOTS slot beats out.
// The accepted command loads the lanes and sets busy; the first slot beat is then registered into out_data.
// Throughput: one slot beat per cycle while out_ready does not stall the output;
// the next command is taken in the cycle the last slot is loaded into the output register.
// Reset (synchronous, rst high): frame engine idle, output empty, duties 15 and 7.
module dshot_four_lane_frame_encoder_core
  import dshot4fe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  cmd_t                   in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output slot_t                  out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [DUTY_W-1:0]      cfg_data
);

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(FRAME_SLOTS - 1);

  logic              busy;
  logic [SLOT_W-1:0] slot;
  logic [DUTY_W-1:0] one_bit_duty;
  logic [DUTY_W-1:0] zero_bit_duty;

  logic              advance;
  logic              accept;
  logic              last;
  lane_ctrl_t        lane_ctrl;
  logic [VALUE_W-1:0] lane_value [LANE_FIELDS];
  logic [LANE_FIELDS-1:0] lane_bit;
  logic [DUTY_W-1:0] lane_duty [LANE_FIELDS];
  slot_t             slot_next;

  assign advance   = busy && (!out_valid || out_ready);
  assign last      = (slot == LAST_SLOT);
  assign in_ready  = !busy || (advance && last);
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign lane_ctrl.load  = accept;
  assign lane_ctrl.shift = advance;

  assign lane_value[0] = in_data.motor0_value;
  assign lane_value[1] = in_data.motor1_value;
  assign lane_value[2] = in_data.motor2_value;
  assign lane_value[3] = in_data.motor3_value;

  for (genvar i = 0; i < LANE_FIELDS; i++) begin : g_lane
    if (i < MOTOR_LANES) begin : g_built
      dshot4fe_lane u_lane (
        .clk       (clk),
        .ctrl      (lane_ctrl),
        .value     (lane_value[i]),
        .telemetry (in_data.telemetry_request),
        .bit_out   (lane_bit[i])
      );
      always_comb begin
        if (slot < SLOT_W'(DATA_SLOTS)) begin
          lane_duty[i] = lane_bit[i] ? one_bit_duty : zero_bit_duty;
        end else begin
          lane_duty[i] = '0;
        end
      end
    end else begin : g_absent
      assign lane_bit[i]  = 1'b0;
      assign lane_duty[i] = '0;
    end
  end

  // merge lane duties into one slot beat
  always_comb begin
    slot_next.slot_number = 5'(slot);
    slot_next.motor0_duty = lane_duty[0];
    slot_next.motor1_duty = lane_duty[1];
    slot_next.motor2_duty = lane_duty[2];
    slot_next.motor3_duty = lane_duty[3];
    slot_next.frame_end   = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy          <= 1'b0;
      slot          <= '0;
      out_valid     <= 1'b0;
      one_bit_duty  <= ONE_BIT_DUTY_RESET;
      zero_bit_duty <= ZERO_BIT_DUTY_RESET;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ONE_BIT_DUTY:  one_bit_duty  <= cfg_data;
          REG_ZERO_BIT_DUTY: zero_bit_duty <= cfg_data;
          default: ;
        endcase
      end
      if (advance) begin
        out_valid <= 1'b1;
        out_data  <= slot_next;
        slot      <= last ? '0 : slot + SLOT_W'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // a new command on the last slot keeps the engine running
      if (accept) begin
        busy <= 1'b1;
      end else if (advance && last) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
